@@ rtl/assert_macros.svh @@
// assertion macros for the rtl files, included by the scan controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/rrss_pkg.sv @@
// types and constants of the range sensor scanner
`default_nettype none
package rrss_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MM_W     = 12;
  localparam int PERIOD_W = 8;
  localparam int DIST_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_SENSORS = 8;

  // sample thresholds and scale
  localparam int FAULT_LIMIT = 1024 / 5 / 4;
  localparam int LOW_END     = 1024 / 5;
  localparam int SCALE_DIV   = 4 * 1024 / 5;
  localparam logic [DIST_W-1:0] INVALID_MM = 16'hFFFF;

  // quotient by SCALE_DIV through a reciprocal multiply, exact for the product range
  localparam int OFFS_W  = SAMPLE_W;
  localparam int PROD_W  = OFFS_W + MM_W;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W = 23;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam int QPROD_W = PROD_W + RECIP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOO_FAR      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 2'd3;

  localparam logic [MM_W-1:0]     MIN_DISTANCE_RST = 12'd100;
  localparam logic [MM_W-1:0]     MAX_DISTANCE_RST = 12'd800;
  localparam logic [MM_W-1:0]     TOO_FAR_RST      = 12'd650;
  localparam logic [PERIOD_W-1:0] PERIOD_RST       = 8'd10;

  typedef struct packed {
    logic [MM_W-1:0]     min_distance_mm;
    logic [MM_W-1:0]     max_distance_mm;
    logic [MM_W-1:0]     too_far_mm;
    logic [PERIOD_W-1:0] period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
  } in_beat_t;

  typedef struct packed {
    logic              fault;
    logic [MM_W-1:0]   quot;
  } conv_beat_t;

  typedef struct packed {
    logic              measure_done;
    logic              reading_stored;
    logic [1:0]        measured_sensor;
    logic [1:0]        selected_sensor;
    logic [3:0]        sync_lines;
    logic [DIST_W-1:0] distance_zero;
    logic [DIST_W-1:0] distance_one;
    logic [DIST_W-1:0] distance_two;
    logic [DIST_W-1:0] distance_three;
  } out_beat_t;

endpackage
`default_nettype wire

@@ rtl/rrss_stream_if.sv @@
// valid/ready stream channel with a typed payload
`default_nettype none
interface rrss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/round_robin_range_sensor_scanner.sv @@
// top level of the round-robin range sensor scanner
//
//   channel   dir  payload                                 width
//   samples   in   adc_sample                              10
//   results   out  done, stored, sensors, sync, 4 x dist   74
//   cfg_*     in   register write (index 2b, data 12b)     -
//
// one beat per cycle sustained while results are accepted; each sample is registered in turn in
// the input reg, span product reg, reciprocal quotient reg and result reg
// each stage holds while its successor is full, so bubbles close up under stalls
// synchronous reset: distances read invalid, counter zero, all sync lines low
`default_nettype none
module round_robin_range_sensor_scanner
  import rrss_pkg::*;
#(
  parameter int SENSOR_COUNT = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rrss_stream_if.sink                samples,
  rrss_stream_if.source              results
);

  cfg_t cfg;

  rrss_stream_if #(.payload_t(conv_beat_t)) conv_ch ();

  rrss_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rrss_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .conv    (conv_ch.source)
  );

  rrss_scan_ctrl #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_scan_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .conv    (conv_ch.sink),
    .results (results)
  );

endmodule
`default_nettype wire

@@ rtl/rrss_cfg_regs.sv @@
// configuration registers of the scanner
`default_nettype none
module rrss_cfg_regs
  import rrss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_distance_mm <= MIN_DISTANCE_RST;
      cfg.max_distance_mm <= MAX_DISTANCE_RST;
      cfg.too_far_mm      <= TOO_FAR_RST;
      cfg.period_ticks    <= PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_DISTANCE: cfg.min_distance_mm <= cfg_data[MM_W-1:0];
        REG_MAX_DISTANCE: cfg.max_distance_mm <= cfg_data[MM_W-1:0];
        REG_TOO_FAR:      cfg.too_far_mm      <= cfg_data[MM_W-1:0];
        REG_PERIOD:       cfg.period_ticks    <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrss_convert.sv @@
// sample to distance pipeline: input reg, span product, reciprocal quotient
`default_nettype none
module rrss_convert
  import rrss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  rrss_stream_if.sink     samples,
  rrss_stream_if.source   conv
);

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s2_valid;
  logic                s2_fault;
  logic [PROD_W-1:0]   s2_prod;
  logic                s3_valid;
  logic                s3_fault;
  logic [MM_W-1:0]     s3_quot;

  logic                en1;
  logic                en2;
  logic                en3;
  logic [MM_W-1:0]     span;
  logic                s1_fault;
  logic                s1_low;
  logic [OFFS_W-1:0]   offs;
  logic [QPROD_W-1:0]  qprod;

  // each stage moves when its successor has room
  assign en3 = !s3_valid || conv.ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign samples.ready = en1;

  // inverted limits collapse the span to zero
  assign span = (cfg.max_distance_mm >= cfg.min_distance_mm) ?
                (cfg.max_distance_mm - cfg.min_distance_mm) : '0;
  assign s1_fault = s1_sample <= SAMPLE_W'(FAULT_LIMIT);
  assign s1_low   = s1_sample <= SAMPLE_W'(LOW_END);
  assign offs     = s1_low ? '0 : (s1_sample - SAMPLE_W'(LOW_END));
  assign qprod    = QPROD_W'(s2_prod) * QPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= samples.valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && samples.valid) begin
      s1_sample <= samples.payload.adc_sample;
    end
    if (en2 && s1_valid) begin
      s2_fault <= s1_fault;
      s2_prod  <= PROD_W'(offs) * PROD_W'(span);
    end
    if (en3 && s2_valid) begin
      s3_fault <= s2_fault;
      s3_quot  <= qprod[RECIP_SHIFT +: MM_W];
    end
  end

  assign conv.valid         = s3_valid;
  assign conv.payload.fault = s3_fault;
  assign conv.payload.quot  = s3_quot;

endmodule
`default_nettype wire

@@ rtl/rrss_scan_ctrl.sv @@
// round-robin scan state, distance store and result register
`default_nettype none
module rrss_scan_ctrl
  import rrss_pkg::*;
#(
  parameter int SENSOR_COUNT = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  rrss_stream_if.sink     conv,
  rrss_stream_if.source   results
);
  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(SENSOR_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

  logic [IDX_W-1:0]        active;
  logic [PERIOD_W-1:0]     ticks_left;
  logic                    first_pass_done;
  logic [SENSOR_COUNT-1:0] sync;
  logic [DIST_W-1:0]       dist_mm [SENSOR_COUNT];
  logic                    out_valid;
  out_beat_t               out_beat;

  logic [IDX_W-1:0]        active_next;
  logic [PERIOD_W-1:0]     ticks_left_next;
  logic [SENSOR_COUNT-1:0] sync_next;
  logic [DIST_W-1:0]       dist_mm_next [SENSOR_COUNT];
  logic                    stored;
  logic [IDX_W-1:0]        measured;
  logic                    expire;
  logic                    step;
  logic                    out_en;
  logic [MM_W:0]           mm_sum;
  logic [DIST_W-1:0]       mm;
  logic [PERIOD_W-1:0]     ticks_dec;
  logic [MAX_SENSORS-1:0]  measured_wide;
  logic [MAX_SENSORS-1:0]  active_wide;
  logic [MAX_SENSORS-1:0]  sync_wide;
  logic [DIST_W-1:0]       dist_field [4];
  logic [SENSOR_COUNT-1:0] sel_onehot;
  out_beat_t               beat_next;

  assign out_en     = !out_valid || results.ready;
  assign conv.ready = out_en;
  assign step       = conv.valid && out_en;
  assign expire     = ticks_left == '0;
  assign ticks_dec  = ticks_left - PERIOD_W'(1);

  // distance from the quotient, then the fault and too-far checks
  assign mm_sum = {1'b0, cfg.min_distance_mm} + {1'b0, conv.payload.quot};
  assign mm = (conv.payload.fault || (mm_sum >= {1'b0, cfg.too_far_mm})) ?
              INVALID_MM : DIST_W'(mm_sum);

  always_comb begin
    active_next     = active;
    sync_next       = sync;
    dist_mm_next    = dist_mm;
    stored          = 1'b0;
    measured        = '0;
    ticks_left_next = ticks_dec;
    if (expire) begin
      if (first_pass_done) begin
        sync_next[active]    = 1'b0;
        dist_mm_next[active] = mm;
        stored               = 1'b1;
        measured             = active;
        active_next          = (active == LAST_IDX) ? '0 : active + IDX_W'(1);
      end
      sync_next[active_next] = 1'b1;
      ticks_left_next        = cfg.period_ticks;
    end
  end

  // fields report only their low bits, missing sensors read invalid
  assign measured_wide = MAX_SENSORS'(measured);
  assign active_wide   = MAX_SENSORS'(active_next);
  assign sync_wide     = MAX_SENSORS'(sync_next);

  for (genvar j = 0; j < 4; j++) begin : g_field
    if (j < SENSOR_COUNT) begin : g_real
      assign dist_field[j] = dist_mm_next[j];
    end else begin : g_absent
      assign dist_field[j] = INVALID_MM;
    end
  end

  always_comb begin
    beat_next.measure_done    = expire;
    beat_next.reading_stored  = stored;
    beat_next.measured_sensor = measured_wide[1:0];
    beat_next.selected_sensor = active_wide[1:0];
    beat_next.sync_lines      = sync_wide[3:0];
    beat_next.distance_zero   = dist_field[0];
    beat_next.distance_one    = dist_field[1];
    beat_next.distance_two    = dist_field[2];
    beat_next.distance_three  = dist_field[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= '0;
      ticks_left      <= '0;
      first_pass_done <= 1'b0;
      sync            <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        dist_mm[i] <= INVALID_MM;
      end
    end else begin
      if (out_en) out_valid <= conv.valid;
      if (step) begin
        active     <= active_next;
        ticks_left <= ticks_left_next;
        sync       <= sync_next;
        dist_mm    <= dist_mm_next;
        if (expire) first_pass_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_beat <= beat_next;
  end

  assign results.valid   = out_valid;
  assign results.payload = out_beat;

  assign sel_onehot = {{(SENSOR_COUNT-1){1'b0}}, 1'b1} << active;

  `ASSERT_ALWAYS(a_sync_onehot0, clk, rst, $onehot0(sync), "more than one sync line high")
  `ASSERT_IMPLIES(a_sync_active, clk, rst, first_pass_done, sync == sel_onehot,
    "sync line does not match selected sensor")
  `ASSERT_IMPLIES(a_sync_idle, clk, rst, !first_pass_done, sync == '0,
    "sync line raised before first measurement")
  `ASSERT_IMPLIES(a_store_needs_done, clk, rst, out_valid && out_beat.reading_stored,
    out_beat.measure_done, "reading stored without measurement end")
  `ASSERT_NEXT(a_countdown, clk, rst, step && !expire, ticks_left == $past(ticks_dec),
    "wait counter did not count down")

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench of the round-robin range sensor scanner
module tb;
  import rrss_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 37;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 120;
  localparam int PRINT_CAP     = 40;
  localparam int PHASES        = 11;
  localparam int DIRECTED_ROWS = 16;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    out_beat_t           want;
  } directed_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] min_word;
    logic [CFG_DATA_W-1:0] max_word;
    logic [CFG_DATA_W-1:0] far_word;
    logic [CFG_DATA_W-1:0] period_word;
    int                    count;
    bit                    calm;
  } phase_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rrss_stream_if #(.payload_t(in_beat_t))  samples ();
  rrss_stream_if #(.payload_t(out_beat_t)) results ();

  round_robin_range_sensor_scanner #(.SENSOR_COUNT(4)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .results   (results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scanner model state and register copies
  logic [MM_W-1:0]     min_mm = MIN_DISTANCE_RST;
  logic [MM_W-1:0]     max_mm = MAX_DISTANCE_RST;
  logic [MM_W-1:0]     far_mm = TOO_FAR_RST;
  logic [PERIOD_W-1:0] period = PERIOD_RST;
  logic [1:0]          scan_sensor = '0;
  logic [PERIOD_W-1:0] wait_ticks = '0;
  logic                primed = 1'b0;
  logic [3:0]          sync_bits = '0;
  logic [DIST_W-1:0]   stored_mm [4] = '{INVALID_MM, INVALID_MM, INVALID_MM, INVALID_MM};

  out_beat_t     due_scans [$];
  directed_row_t directed_rows [DIRECTED_ROWS];
  phase_t        phases [PHASES];

  int  mismatches = 0;
  int  sent_count = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  function automatic logic [DIST_W-1:0] sample_to_mm(logic [SAMPLE_W-1:0] v);
    int unsigned s, span, mm;
    s = v;
    span = (max_mm >= min_mm) ? max_mm - min_mm : 0;
    if (s <= FAULT_LIMIT) mm = INVALID_MM;
    else if (s <= LOW_END) mm = min_mm;
    else mm = min_mm + ((s - LOW_END) * span) / SCALE_DIV;
    if (mm >= far_mm) mm = INVALID_MM;
    return mm[DIST_W-1:0];
  endfunction

  // one tick of the scanner: advances the model and returns the beat it reports
  function automatic out_beat_t scan_tick(logic [SAMPLE_W-1:0] v);
    out_beat_t o;
    logic [1:0] cur;
    o = '0;
    if (wait_ticks == 0) begin
      if (primed) begin
        cur = scan_sensor;
        sync_bits[cur] = 1'b0;
        stored_mm[cur] = sample_to_mm(v);
        o.reading_stored = 1'b1;
        o.measured_sensor = cur;
        scan_sensor = cur + 2'd1;
      end
      primed = 1'b1;
      sync_bits[scan_sensor] = 1'b1;
      wait_ticks = period;
      o.measure_done = 1'b1;
    end else begin
      wait_ticks = wait_ticks - 1'b1;
    end
    o.selected_sensor = scan_sensor;
    o.sync_lines = sync_bits;
    o.distance_zero = stored_mm[0];
    o.distance_one = stored_mm[1];
    o.distance_two = stored_mm[2];
    o.distance_three = stored_mm[3];
    return o;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] edges [6] = '{10'd0, 10'd51, 10'd52, 10'd204, 10'd205, 10'd1023};
    case ($urandom_range(9))
      0: return SAMPLE_W'($urandom_range(FAULT_LIMIT));
      1: return SAMPLE_W'($urandom_range(LOW_END, FAULT_LIMIT + 1));
      2: return edges[$urandom_range(5)];
      default: return SAMPLE_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_DISTANCE: min_mm = data[MM_W-1:0];
      REG_MAX_DISTANCE: max_mm = data[MM_W-1:0];
      REG_TOO_FAR:      far_mm = data[MM_W-1:0];
      REG_PERIOD:       period = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(phase_t ph);
    write_reg(REG_MIN_DISTANCE, ph.min_word);
    write_reg(REG_MAX_DISTANCE, ph.max_word);
    write_reg(REG_TOO_FAR, ph.far_word);
    write_reg(REG_PERIOD, ph.period_word);
    cfg_wr_en <= 1'b0;
  endtask

  // valid stays high across back-to-back beats
  task automatic send_sample(logic [SAMPLE_W-1:0] v, bit typed, out_beat_t want);
    out_beat_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.payload <= v;
    do @(posedge clk); while (!samples.ready);
    predicted = scan_tick(v);
    due_scans.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic drain();
    samples.valid <= 1'b0;
    while (due_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_left != 0) begin
      results.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      results.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    out_beat_t got, want;
    if (!rst && results.valid && results.ready) begin
      got = results.payload;
      if (due_scans.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = due_scans.pop_front();
        check_field("measure_done", DIST_W'(got.measure_done), DIST_W'(want.measure_done));
        check_field("reading_stored", DIST_W'(got.reading_stored),
                    DIST_W'(want.reading_stored));
        check_field("measured_sensor", DIST_W'(got.measured_sensor),
                    DIST_W'(want.measured_sensor));
        check_field("selected_sensor", DIST_W'(got.selected_sensor),
                    DIST_W'(want.selected_sensor));
        check_field("sync_lines", DIST_W'(got.sync_lines), DIST_W'(want.sync_lines));
        check_field("distance_zero", got.distance_zero, want.distance_zero);
        check_field("distance_one", got.distance_one, want.distance_one);
        check_field("distance_two", got.distance_two, want.distance_two);
        check_field("distance_three", got.distance_three, want.distance_three);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples.valid = 1'b0;
    samples.payload = '0;

    // period 0 with default limits: every tick measures, first tick only primes
    directed_rows = '{
      '{10'd1023, 1'b1, '{1'b1, 1'b0, 2'd0, 2'd0, 4'b0001,
                          INVALID_MM, INVALID_MM, INVALID_MM, INVALID_MM}},
      '{10'd0,    1'b1, '{1'b1, 1'b1, 2'd0, 2'd1, 4'b0010,
                          INVALID_MM, INVALID_MM, INVALID_MM, INVALID_MM}},
      '{10'd51,   1'b1, '{1'b1, 1'b1, 2'd1, 2'd2, 4'b0100,
                          INVALID_MM, INVALID_MM, INVALID_MM, INVALID_MM}},
      '{10'd52,   1'b1, '{1'b1, 1'b1, 2'd2, 2'd3, 4'b1000,
                          INVALID_MM, INVALID_MM, 16'd100, INVALID_MM}},
      '{10'd204,  1'b1, '{1'b1, 1'b1, 2'd3, 2'd0, 4'b0001,
                          INVALID_MM, INVALID_MM, 16'd100, 16'd100}},
      // full scale lands past the too-far limit
      '{10'd1023, 1'b1, '{1'b1, 1'b1, 2'd0, 2'd1, 4'b0010,
                          INVALID_MM, INVALID_MM, 16'd100, 16'd100}},
      '{10'd205,  1'b0, '0},
      '{10'd206,  1'b0, '0},
      '{10'd512,  1'b0, '0},
      '{10'd819,  1'b0, '0},
      '{10'd1022, 1'b0, '0},
      '{10'h2aa,  1'b0, '0},
      '{10'h155,  1'b0, '0},
      '{10'd53,   1'b0, '0},
      '{10'd203,  1'b0, '0},
      '{10'd700,  1'b0, '0}
    };

    phases[0]  = '{12'd100,  12'd800,  12'd650,  12'd0,   0,   1'b0};
    phases[1]  = '{12'd100,  12'd800,  12'd650,  12'd3,   110, 1'b1};
    phases[2]  = '{12'd0,    12'd4095, 12'd4095, 12'd0,   110, 1'b0};
    // inverted limits
    phases[3]  = '{12'd4095, 12'd0,    12'd4095, 12'd1,   110, 1'b0};
    phases[4]  = '{12'd300,  12'd200,  12'd4000, 12'd2,   110, 1'b0};
    phases[5]  = '{12'd0,    12'd4095, 12'd0,    12'd0,   100, 1'b0};
    phases[6]  = '{12'd50,   12'd3000, 12'd2000, 12'd255, 60,  1'b0};
    // shorter period written mid-countdown, upper data bits set
    phases[7]  = '{12'd50,   12'd3000, 12'd2000, 12'hf01, 200, 1'b0};
    for (int k = 8; k < PHASES; k++) begin
      phases[k] = '{CFG_DATA_W'($urandom_range(4095)), CFG_DATA_W'($urandom_range(4095)),
                    CFG_DATA_W'($urandom_range(4095)),
                    {4'($urandom_range(15)), 8'($urandom_range(4))}, 100, 1'b0};
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    load_settings(phases[0]);
    foreach (directed_rows[r])
      send_sample(directed_rows[r].sample, directed_rows[r].typed, directed_rows[r].want);

    for (int p = 1; p < PHASES; p++) begin
      drain();
      load_settings(phases[p]);
      calm = phases[p].calm;
      repeat (phases[p].count) send_sample(pick_sample(), 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
